// ===== src/gir_pkg.sv =====
`timescale 1ns / 1ps

package gir_pkg;

  // Default frame geometry and coefficient format
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 14;

  // Register reset values
  localparam logic [8:0]         WIDTH_RST  = 9'd256;
  localparam logic [8:0]         HEIGHT_RST = 9'd256;
  localparam logic signed [15:0] COS_RST    = 16'sd8607;
  localparam logic signed [15:0] SIN_RST    = 16'sd13941;

  // Register and port widths
  localparam int SIZE_REG_W = 9;
  localparam int COEF_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int PIX_W      = 8;

  // floor(sum / 3) for sum <= 765: (sum * 683) >> 11
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int SUM_W      = 10;
  localparam int DIV3_PW    = 21;

  // Configuration register map
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COS    = 2'd2,
    REG_SIN    = 2'd3
  } cfg_reg_t;

  // Control tag that travels with each item through the mapping stages
  typedef struct packed {
    logic vld;    // stage holds an item
    logic rd;     // read item (else store item)
    logic wr_ok;  // store lands on the frame
  } tag_t;

  // Active size: zero counts as one, above the frame counts as the frame
  function automatic int clamp_size(logic [8:0] v, int maxv);
    int s;
    s = int'(v);
    if (s < 1) s = 1;
    if (s > maxv) s = maxv;
    return s;
  endfunction

endpackage

// ===== src/gray_image_rotator.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                        Direction
// input     in_valid/in_stall, in_action, in_col,        into block
//           in_row, in_red, in_green, in_blue
// result    out_valid/out_stall, out_gray_value,         out of block
//           out_inside_res
// config    cfg_we, cfg_index, cfg_data                  into block
//
// One item per cycle while the result is not stalled; a read item's result
// passes the stage chain: input, products, sums, truncation with the frame
// store access, then the store read data. Store items give no result.
// rst_n clears the pipeline valid bits and loads the register reset values; the frame store is not cleared.
// A stalled result freezes the whole pipeline, so in_stall follows it.
module gray_image_rotator #(
  parameter int MAX_WIDTH  = gir_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gir_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = gir_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [gir_pkg::PIX_W-1:0]       in_col,
  input  logic [gir_pkg::PIX_W-1:0]       in_row,
  input  logic [gir_pkg::PIX_W-1:0]       in_red,
  input  logic [gir_pkg::PIX_W-1:0]       in_green,
  input  logic [gir_pkg::PIX_W-1:0]       in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gir_pkg::PIX_W-1:0]       out_gray_value,
  output logic                            out_inside_res,
  input  logic                            cfg_we,
  input  gir_pkg::cfg_reg_t               cfg_index,
  input  logic [gir_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gir_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WSW   = $clog2(MAX_WIDTH + 1);
  localparam int HSW   = $clog2(MAX_HEIGHT + 1);
  localparam int SZW   = (WSW > HSW) ? WSW : HSW;
  localparam int CW    = SZW - 1;
  localparam int DW    = (SZW > 9) ? SZW : 9;
  localparam int SWA   = DW + COEF_W;
  localparam int SWB   = CW + FRAC_BITS + 1;
  localparam int SW    = ((SWA > SWB) ? SWA : SWB) + 1;
  localparam int TW    = SW - FRAC_BITS;
  localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);

  // Configuration, sizes kept already clamped
  logic [WSW-1:0]           width_r;
  logic [HSW-1:0]           height_r;
  logic signed [COEF_W-1:0] cos_r, sin_r;
  logic [CW-1:0]            cx, cy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WSW'(clamp_size(WIDTH_RST, MAX_WIDTH));
      height_r <= HSW'(clamp_size(HEIGHT_RST, MAX_HEIGHT));
      cos_r    <= COS_RST;
      sin_r    <= SIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= WSW'(clamp_size(cfg_data[SIZE_REG_W-1:0], MAX_WIDTH));
        REG_HEIGHT: height_r <= HSW'(clamp_size(cfg_data[SIZE_REG_W-1:0], MAX_HEIGHT));
        REG_COS:    cos_r    <= $signed(cfg_data[COEF_W-1:0]);
        REG_SIN:    sin_r    <= $signed(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cx = CW'(width_r >> 1);
  assign cy = CW'(height_r >> 1);

  // Pipeline moves unless a result is held
  logic adv;
  logic f_vld_r;
  assign adv      = !(f_vld_r && out_stall);
  assign in_stall = !adv;

  // Stage A: take the item, center the coordinate, sum the components
  tag_t                 a_tag_r;
  logic [PIX_W-1:0]     a_col_r, a_row_r;
  logic [SUM_W-1:0]     a_sum_r;
  logic signed [DW-1:0] a_dx_r, a_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
    end else if (adv) begin
      a_tag_r.vld   <= in_valid;
      a_tag_r.rd    <= in_action;
      a_tag_r.wr_ok <= (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_col_r <= in_col;
      a_row_r <= in_row;
      a_sum_r <= SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
      a_dx_r  <= $signed(DW'(in_col)) - $signed(DW'(cx));
      a_dy_r  <= $signed(DW'(in_row)) - $signed(DW'(cy));
    end
  end

  // Rotation stages
  tag_t                 d_tag;
  logic signed [TW-1:0] d_xs, d_ys;

  gir_xform #(
    .DW        (DW),
    .CW        (CW),
    .FRAC_BITS (FRAC_BITS),
    .TW        (TW)
  ) u_xform (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .tag_i (a_tag_r),
    .dx_i  (a_dx_r),
    .dy_i  (a_dy_r),
    .cos_i (cos_r),
    .sin_i (sin_r),
    .cx_i  (cx),
    .cy_i  (cy),
    .tag_o (d_tag),
    .xs_o  (d_xs),
    .ys_o  (d_ys)
  );

  // Store data alongside the rotation stages: gray level and frame address
  logic [DIV3_PW-1:0] div3_prod;
  logic [AW-1:0]      waddr_a;
  logic [PIX_W-1:0]   b_gray_r, c_gray_r, d_gray_r;
  logic [AW-1:0]      b_waddr_r, c_waddr_r, d_waddr_r;

  assign div3_prod = DIV3_PW'(a_sum_r) * DIV3_PW'(DIV3_MUL);
  assign waddr_a   = AW'(AW'(a_row_r) * MW_A) + AW'(a_col_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_gray_r  <= div3_prod[DIV3_SHIFT +: PIX_W];
      b_waddr_r <= waddr_a;
      c_gray_r  <= b_gray_r;
      c_waddr_r <= b_waddr_r;
      d_gray_r  <= c_gray_r;
      d_waddr_r <= c_waddr_r;
    end
  end

  // Stage D: bounds test, read address, frame store access
  logic          d_inside;
  logic [AW-1:0] raddr;
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [PIX_W-1:0] ram_rdata;

  assign d_inside = (d_xs >= 0) && (d_xs < $signed(TW'(width_r))) &&
                    (d_ys >= 0) && (d_ys < $signed(TW'(height_r)));
  assign raddr    = AW'(AW'(d_ys[YW-1:0]) * MW_A) + AW'(d_xs[XW-1:0]);
  assign ram_we   = !d_tag.rd;
  assign ram_en   = adv && d_tag.vld && (d_tag.rd ? d_inside : d_tag.wr_ok);
  assign ram_addr = d_tag.rd ? raddr : d_waddr_r;

  gir_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (d_gray_r),
    .rdata (ram_rdata)
  );

  // Stage F: result from the store read data
  logic f_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= d_tag.vld && d_tag.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_inside_r <= d_inside;
    end
  end

  assign out_valid      = f_vld_r;
  assign out_inside_res = f_inside_r;
  assign out_gray_value = f_inside_r ? ram_rdata : '0;

`ifndef SYNTHESIS
  // Outside source reads as zero
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |-> out_gray_value == '0)
    else $error("outside source gave a nonzero gray value");

  // Store read data holds while the result is stalled
  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(ram_rdata))
    else $error("frame read data changed under stall");

  // A new result comes only from a read item leaving the mapping stages
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(d_tag.vld && d_tag.rd))
    else $error("result without a read item");
`endif

endmodule

// ===== src/gir_ram.sv =====
`timescale 1ns / 1ps

module gir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read; data holds while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/gir_xform.sv =====
`timescale 1ns / 1ps

module gir_xform #(
  parameter int DW        = 9,   // signed width of dx, dy
  parameter int CW        = 8,   // width of the center coordinates
  parameter int FRAC_BITS = 14,
  parameter int TW        = 12   // signed width of the mapped source coordinate
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  gir_pkg::tag_t            tag_i,
  input  logic signed [DW-1:0]     dx_i,
  input  logic signed [DW-1:0]     dy_i,
  input  logic signed [15:0]       cos_i,
  input  logic signed [15:0]       sin_i,
  input  logic [CW-1:0]            cx_i,
  input  logic [CW-1:0]            cy_i,
  output gir_pkg::tag_t            tag_o,
  output logic signed [TW-1:0]     xs_o,
  output logic signed [TW-1:0]     ys_o
);
  import gir_pkg::*;

  localparam int PW = COEF_W + DW;
  localparam int SW = TW + FRAC_BITS;
  localparam logic [SW-1:0] BIAS = SW'((1 << FRAC_BITS) - 1);

  tag_t tag1_r, tag2_r, tag3_r;
  logic signed [PW-1:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [SW-1:0] sum_x_r, sum_y_r;
  logic [SW-1:0] sum_x_nxt, sum_y_nxt, tr_x, tr_y;

  // Rotation sums with the center added back in fixed point
  assign sum_x_nxt = SW'(p_xc_r) + SW'(p_ys_r) + SW'({cx_i, {FRAC_BITS{1'b0}}});
  assign sum_y_nxt = SW'(p_yc_r) - SW'(p_xs_r) + SW'({cy_i, {FRAC_BITS{1'b0}}});

  // Truncate toward zero: bias negatives before the arithmetic shift
  assign tr_x = sum_x_r + (sum_x_r[SW-1] ? BIAS : '0);
  assign tr_y = sum_y_r + (sum_y_r[SW-1] ? BIAS : '0);

  // Tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (adv) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  // Products, sums, truncation
  always_ff @(posedge clk) begin
    if (adv) begin
      p_xc_r  <= cos_i * dx_i;
      p_ys_r  <= sin_i * dy_i;
      p_xs_r  <= sin_i * dx_i;
      p_yc_r  <= cos_i * dy_i;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      xs_o    <= TW'($signed(tr_x) >>> FRAC_BITS);
      ys_o    <= TW'($signed(tr_y) >>> FRAC_BITS);
    end
  end

  assign tag_o = tag3_r;

endmodule

// ===== test/gray_image_rotator_tb.sv =====
`timescale 1ns / 1ps

module gray_image_rotator_tb;
  import gir_pkg::*;

  localparam logic ACT_STORE   = 1'b0;
  localparam logic ACT_READ    = 1'b1;
  localparam int   FRAME_W     = MAX_WIDTH_DEF;
  localparam int   FRAME_H     = MAX_HEIGHT_DEF;
  localparam int   QBITS       = FRAC_BITS_DEF;
  localparam int   ITEM_TARGET = 1050;
  localparam int   LONG_HOLD   = 120;
  localparam int   MAX_PRINTS  = 40;

  typedef struct packed {
    logic       action;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       src_in;
  } gray_result_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic                  in_action      = ACT_STORE;
  logic [PIX_W-1:0]      in_col         = '0;
  logic [PIX_W-1:0]      in_row         = '0;
  logic [PIX_W-1:0]      in_red         = '0;
  logic [PIX_W-1:0]      in_green       = '0;
  logic [PIX_W-1:0]      in_blue        = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [PIX_W-1:0]      out_gray_value;
  logic                  out_inside_res;
  logic                  cfg_we         = 1'b0;
  cfg_reg_t              cfg_index      = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  // Shadow of the block's registers and frame store
  logic [8:0]         width_shadow;
  logic [8:0]         height_shadow;
  logic signed [15:0] cos_shadow;
  logic signed [15:0] sin_shadow;
  logic [7:0]         frame_model [0:FRAME_W*FRAME_H-1];

  // Stimulus bookkeeping: entries that some queued store will have written
  bit                 planned_px [0:FRAME_W*FRAME_H-1];
  pix_item_t          pixel_items[$];
  gray_result_t       expected_pixels[$];
  int                 sent_count   = 0;
  int                 taken_count  = 0;
  int                 error_count  = 0;
  logic               in_fire      = 1'b0;

  // Driver and receiver pacing
  int                 gap_left     = 0;
  int                 burst_left   = 0;
  int                 hold_asked   = 0;
  int                 hold_served  = 0;
  int                 hold_left    = 0;
  int                 run_left     = 0;
  logic               run_stall    = 1'b0;
  pix_item_t          drv_item;

  gray_image_rotator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gray_value (out_gray_value),
    .out_inside_res (out_inside_res),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #10_000_000;
    $display("gray_image_rotator_tb failed");
    $finish;
  end

  task automatic flag_error(string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Register value as the block uses it: 0 -> 1, above the frame -> frame size
  function automatic int eff_size(logic [8:0] v, int maxv);
    if (v == 9'd0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Q-format product sum divided by 2^QBITS, rounded toward zero
  function automatic int q_trunc(longint v);
    if (v >= 0) return int'(v >>> QBITS);
    return -int'((-v) >>> QBITS);
  endfunction

  // Destination pixel -> source pixel under the current rotation
  function automatic void map_source(input int col, row, output int xs, ys,
                                     output bit src_in);
    int     w, h, cx, cy, dx, dy;
    longint c, s;
    w  = eff_size(width_shadow, FRAME_W);
    h  = eff_size(height_shadow, FRAME_H);
    cx = w / 2;
    cy = h / 2;
    c  = cos_shadow;
    s  = sin_shadow;
    dx = col - cx;
    dy = row - cy;
    xs = q_trunc(c * dx + s * dy + (longint'(cx) <<< QBITS));
    ys = q_trunc(-s * dx + c * dy + (longint'(cy) <<< QBITS));
    src_in = xs >= 0 && xs < w && ys >= 0 && ys < h;
  endfunction

  // Update the frame model or queue the expected gray level for one item
  task automatic predict_item();
    int           xs, ys;
    bit           src_in;
    gray_result_t px;
    if (in_action == ACT_STORE) begin
      frame_model[int'(in_row) * FRAME_W + int'(in_col)] =
        8'((int'(in_red) + int'(in_green) + int'(in_blue)) / 3);
    end else begin
      map_source(int'(in_col), int'(in_row), xs, ys, src_in);
      px.src_in = src_in;
      px.gray   = src_in ? frame_model[ys * FRAME_W + xs] : 8'd0;
      expected_pixels.push_back(px);
    end
  endtask

  task automatic check_result();
    gray_result_t px;
    if (expected_pixels.size() == 0) begin
      flag_error($sformatf("result gray=%0d inside=%0b with nothing pending",
                           out_gray_value, out_inside_res));
      return;
    end
    px = expected_pixels.pop_front();
    if (out_gray_value !== px.gray)
      flag_error($sformatf("gray_value %0d, want %0d", out_gray_value, px.gray));
    if (out_inside_res !== px.src_in)
      flag_error($sformatf("inside_res %0b, want %0b", out_inside_res, px.src_in));
  endtask

  // Monitor: results first, then accepted items, then register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      width_shadow  <= WIDTH_RST;
      height_shadow <= HEIGHT_RST;
      cos_shadow    <= COS_RST;
      sin_shadow    <= SIN_RST;
      in_fire       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        predict_item();
        taken_count++;
      end
      in_fire <= in_valid && !in_stall;
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_shadow  <= cfg_data[8:0];
          REG_HEIGHT: height_shadow <= cfg_data[8:0];
          REG_COS:    cos_shadow    <= cfg_data;
          REG_SIN:    sin_shadow    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Gap after an item: mostly none or short, sometimes long, with bursts
  function int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: next item goes out once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pixel_items.size() > 0) begin
        drv_item  = pixel_items.pop_front();
        in_action <= drv_item.action;
        in_col    <= drv_item.col;
        in_row    <= drv_item.row;
        in_red    <= drv_item.red;
        in_green  <= drv_item.green;
        in_blue   <= drv_item.blue;
        in_valid  <= 1'b1;
        gap_left  = next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random runs, plus a long hold on request
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_asked) begin
      out_stall <= 1'b1;
      hold_left = LONG_HOLD;
      hold_served++;
    end else if (run_left > 0) begin
      out_stall <= run_stall;
      run_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        run_stall = 1'b0;
        run_left  = $urandom_range(1, 10);
      end else if (r < 65) begin
        run_stall = 1'b0;
        run_left  = $urandom_range(30, 80);
      end else if (r < 92) begin
        run_stall = 1'b1;
        run_left  = $urandom_range(1, 3);
      end else begin
        run_stall = 1'b1;
        run_left  = $urandom_range(8, 30);
      end
      out_stall <= run_stall;
    end
  end

  function automatic logic [7:0] rand_channel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_store(int col, row, logic [7:0] red, green, blue);
    pix_item_t it;
    it.action = ACT_STORE;
    it.col    = 8'(col);
    it.row    = 8'(row);
    it.red    = red;
    it.green  = green;
    it.blue   = blue;
    planned_px[row * FRAME_W + col] = 1'b1;
    pixel_items.push_back(it);
    sent_count++;
  endtask

  // A read whose source pixel was never stored gets a store queued first
  task automatic queue_read(int col, row);
    pix_item_t it;
    int        xs, ys;
    bit        src_in;
    map_source(col, row, xs, ys, src_in);
    if (src_in && !planned_px[ys * FRAME_W + xs])
      queue_store(xs, ys, rand_channel(), rand_channel(), rand_channel());
    it.action = ACT_READ;
    it.col    = 8'(col);
    it.row    = 8'(row);
    it.red    = rand_channel();
    it.green  = rand_channel();
    it.blue   = rand_channel();
    pixel_items.push_back(it);
    sent_count++;
  endtask

  // Mostly reads aimed at the active image, some stray stores and reads
  task automatic random_item();
    int r, w, h;
    w = eff_size(width_shadow, FRAME_W);
    h = eff_size(height_shadow, FRAME_H);
    r = $urandom_range(0, 99);
    if (r < 15)
      queue_store($urandom_range(0, 255), $urandom_range(0, 255),
                  rand_channel(), rand_channel(), rand_channel());
    else if (r < 25)
      queue_read($urandom_range(0, 255), $urandom_range(0, 255));
    else
      queue_read($urandom_range(0, w < 255 ? w + 1 : 255),
                 $urandom_range(0, h < 255 ? h + 1 : 255));
  endtask

  // Everything sent has been taken and every result has come back
  task automatic wait_idle();
    while (taken_count != sent_count || expected_pixels.size() != 0) @(posedge clk);
    // store items may still be in flight
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(int w, h, logic [15:0] c, s, int n, bit corners,
                           bit pause_mid, bit hold);
    wait_idle();
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
    repeat (2) @(posedge clk);
    if (corners) begin
      queue_read(0, 0);
      queue_read(255, 255);
    end
    if (hold) hold_asked++;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_idle();
      random_item();
    end
  endtask

  function automatic int rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 40);
    if (r < 88) return $urandom_range(41, 256);
    if (r < 95) return $urandom_range(257, 511);
    return 0;
  endfunction

  initial begin
    int          phase_no;
    logic [15:0] c_sel, s_sel;
    real         ang;
    int          drain;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry and angle: extreme colors and positions, then reads
    queue_store(0, 0, 8'd255, 8'd255, 8'd255);
    queue_store(255, 255, 8'd0, 8'd0, 8'd0);
    queue_store(255, 0, 8'd255, 8'd255, 8'd254);
    queue_store(0, 255, 8'd1, 8'd1, 8'd0);
    queue_store(128, 128, 8'd2, 8'd2, 8'd2);
    queue_read(0, 0);
    queue_read(255, 255);
    queue_read(128, 128);
    queue_read(255, 0);
    queue_read(0, 255);
    queue_read(128, 0);
    for (int i = 0; i < 150; i++) random_item();

    // Fixed settings: identity with a long receiver hold, tiny image,
    // sizes beyond range, quarter turns and extreme coefficient patterns
    run_phase(256, 256, 16'd16384, 16'd0, 120, 1'b1, 1'b1, 1'b1);
    run_phase(1, 1, 16'd11585, 16'(-11585), 40, 1'b1, 1'b0, 1'b0);
    run_phase(0, 300, 16'(-16384), 16'd0, 60, 1'b1, 1'b0, 1'b0);
    run_phase(511, 0, 16'd0, 16'd16384, 60, 1'b1, 1'b1, 1'b0);
    run_phase(255, 3, 16'h7FFF, 16'h8000, 60, 1'b1, 1'b0, 1'b0);
    run_phase(17, 9, 16'd0, 16'(-16384), 60, 1'b1, 1'b0, 1'b0);
    run_phase(256, 256, 16'h8000, 16'h7FFF, 40, 1'b1, 1'b0, 1'b0);

    // Random geometry and angle until enough items have gone out
    phase_no = 0;
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        ang   = $urandom_range(0, 62831) / 10000.0;
        c_sel = 16'(int'($cos(ang) * 16384.0));
        s_sel = 16'(int'($sin(ang) * 16384.0));
      end else begin
        c_sel = 16'($urandom);
        s_sel = 16'($urandom);
      end
      run_phase(rand_size(), rand_size(), c_sel, s_sel, 80, 1'b0,
                phase_no % 2 == 1, phase_no == 3);
      phase_no++;
    end

    // Drain
    while (taken_count != sent_count) @(posedge clk);
    drain = 0;
    while (expected_pixels.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_pixels.size()));

    if (error_count == 0) begin
      $display("gray_image_rotator_tb passed");
    end else begin
      $display("gray_image_rotator_tb failed");
    end
    $finish;
  end

endmodule
